FILE: design/fla_pkg.sv
package fla_pkg;

  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_SET_HEAD = 2'd2,
    CMD_REBUILD  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_REBUILD
  } state_t;

endpackage

FILE: design/free_list_allocator.sv
// Free-list allocator: a head register and a table of TABLE_DEPTH next links in a
// one-port-write, one-port-read synchronous memory. A request is taken when start
// is high and busy is low; its single result appears on out_* for exactly one
// cycle with out_valid high and must be captured then. Free and set-head requests
// answer without going busy. A non-empty alloc goes through the ALLOC state with
// busy high, since the link of the head entry comes out of the registered memory
// read. An alloc on an empty list answers without going busy. Rebuild writes the
// whole table, one entry a cycle, with busy high, and the result follows. After
// reset the same pass runs with busy high and gives no result; configuration
// writes are taken at any time.
module free_list_allocator
  import fla_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_cmd,
  input  logic [IDX_W-1:0] in_index,
  input  logic             in_set_empty,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_result_index,
  output logic             out_result_empty,
  output logic [1:0]       out_status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW   = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = (LW > CNT_W) ? LW : CNT_W;
  localparam int NCAP = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam logic [LW-1:0] END_MARK = LW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_DEPTH - 1);

  state_t           state_r, state_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0] rb_n_r, rb_n_nxt;
  logic             rb_cmd_r, rb_cmd_nxt;
  logic [AW-1:0]    rb_cnt_r, rb_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             accept;
  logic             head_empty;
  logic [CNT_W-1:0] n_used;
  logic             idx_bad;
  logic [CW-1:0]    rb_next_i;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LW-1:0]    mem_wdata;
  logic [LW-1:0]    mem_rdata;

  fla_link_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign head_empty = (head_r >= END_MARK);
  assign n_used     = (entry_count_r > CNT_W'(NCAP)) ? CNT_W'(NCAP) : entry_count_r;
  assign idx_bad    = ({1'b0, in_index} >= n_used);
  assign rb_next_i  = CW'(rb_cnt_r) + CW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_cmd) == CMD_REBUILD) begin
            state_nxt = ST_REBUILD;
          end else if (cmd_t'(in_cmd) == CMD_ALLOC && !head_empty) begin
            state_nxt = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: state_nxt = ST_IDLE;
      ST_REBUILD: begin
        if (rb_cnt_r == LAST_ENTRY) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt       = head_r;
    rb_n_nxt       = rb_n_r;
    rb_cmd_nxt     = rb_cmd_r;
    rb_cnt_nxt     = rb_cnt_r;
    out_valid_nxt  = 1'b0;
    out_index_nxt  = out_index_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(in_index);
    mem_wdata      = head_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_index_nxt  = '0;
          out_empty_nxt  = 1'b0;
          out_status_nxt = STAT_OK;
          case (cmd_t'(in_cmd))
            CMD_ALLOC: begin
              // non-empty alloc answers once the head's link is read
              if (head_empty) begin
                out_valid_nxt  = 1'b1;
                out_empty_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end
            end
            CMD_FREE: begin
              out_valid_nxt = 1'b1;
              if (idx_bad) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                mem_we   = 1'b1;
                head_nxt = LW'(in_index);
              end
            end
            CMD_SET_HEAD: begin
              out_valid_nxt = 1'b1;
              if (head_empty) begin
                out_empty_nxt = 1'b1;
              end else begin
                out_index_nxt = IDX_W'(head_r);
              end
              if (in_set_empty) begin
                head_nxt = END_MARK;
              end else if (idx_bad) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                head_nxt = LW'(in_index);
              end
            end
            default: begin
              rb_n_nxt   = n_used;
              rb_cmd_nxt = 1'b1;
              rb_cnt_nxt = '0;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = IDX_W'(head_r);
        head_nxt      = mem_rdata;
      end
      ST_REBUILD: begin
        mem_we     = 1'b1;
        mem_waddr  = rb_cnt_r;
        mem_wdata  = (rb_next_i < CW'(rb_n_r)) ? LW'(rb_next_i) : END_MARK;
        rb_cnt_nxt = rb_cnt_r + AW'(1);
        if (rb_cnt_r == LAST_ENTRY) begin
          head_nxt      = (rb_n_r == '0) ? END_MARK : '0;
          out_valid_nxt = rb_cmd_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_REBUILD;
      head_r        <= END_MARK;
      entry_count_r <= ENTRY_COUNT_RST;
      rb_n_r        <= CNT_W'(NCAP);
      rb_cmd_r      <= 1'b0;
      rb_cnt_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      rb_n_r      <= rb_n_nxt;
      rb_cmd_r    <= rb_cmd_nxt;
      rb_cnt_r    <= rb_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_index_r  <= out_index_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_result_empty = out_empty_r;
  assign out_status       = out_status_r;

`ifndef NO_ASSERTIONS
  // an alloc that waits on the memory always had a live head
  a_alloc_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALLOC |-> !head_empty)
    else $error("alloc pending with empty head");

  // the pending alloc answers in the following cycle
  a_alloc_answers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ALLOC |=> out_valid && out_status == STAT_OK && !busy)
    else $error("alloc result missing");

  // an empty status always comes with the empty flag and a zero index
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_result_empty && out_result_index == '0)
    else $error("empty status without empty flag");

  // the table pass ends with the head at entry zero or at the end mark
  a_rebuild_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REBUILD && rb_cnt_r == LAST_ENTRY |=> head_r == '0 || head_r == END_MARK)
    else $error("bad head after rebuild");
`endif

endmodule

FILE: design/fla_link_mem.sv
module fla_link_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

FILE: verif/free_list_allocator_checker.sv
`timescale 1ns / 100ps

module free_list_allocator_checker
  import fla_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_cmd,
  input  logic [IDX_W-1:0] in_index,
  input  logic             in_set_empty,
  input  logic             out_valid,
  input  logic [IDX_W-1:0] out_result_index,
  input  logic             out_result_empty,
  input  logic [1:0]       out_status,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               replies_pending
);

  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             empty;
    status_t          status;
  } reply_t;

  logic [CNT_W-1:0] link_tbl [TABLE_DEPTH];
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] entry_count;
  reply_t           expected_replies [$];

  // entries actually chained, capped by the table and the index width
  function automatic int chained_count();
    int n;
    n = entry_count;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n > 256) n = 256;
    return n;
  endfunction

  function automatic void rebuild_chain();
    int n;
    int i;
    n = chained_count();
    for (i = 0; i < TABLE_DEPTH; i++)
      link_tbl[i] = (i + 1 < n) ? CNT_W'(i + 1) : END_MARK;
    head = (n == 0) ? END_MARK : '0;
  endfunction

  function automatic reply_t allocator_reply(cmd_t cmd, logic [IDX_W-1:0] idx, logic set_empty);
    reply_t r;
    int     n;
    n        = chained_count();
    r.index  = '0;
    r.empty  = 1'b0;
    r.status = STAT_OK;
    case (cmd)
      CMD_ALLOC: begin
        if (head >= TABLE_DEPTH) begin
          r.empty  = 1'b1;
          r.status = STAT_EMPTY;
        end else begin
          r.index = head[IDX_W-1:0];
          head    = link_tbl[head];
        end
      end
      CMD_FREE: begin
        if (idx >= n) begin
          r.status = STAT_RANGE;
        end else begin
          link_tbl[idx] = head;
          head          = CNT_W'(idx);
        end
      end
      CMD_SET_HEAD: begin
        // old head is reported even when the new one is refused
        if (head >= TABLE_DEPTH) r.empty = 1'b1;
        else r.index = head[IDX_W-1:0];
        if (set_empty) head = END_MARK;
        else if (idx >= n) r.status = STAT_RANGE;
        else head = CNT_W'(idx);
      end
      default: begin
        rebuild_chain();
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string msg);
    if (mismatch_count < 10) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      entry_count = ENTRY_COUNT_RST;
      rebuild_chain();
      expected_replies.delete();
    end else begin
      // a result never belongs to a request taken at the same edge
      if (out_valid === 1'b1) begin
        if (expected_replies.size() == 0) begin
          flag($sformatf("result with no request waiting: index %0d empty %0d status %0d",
                         out_result_index, out_result_empty, out_status));
        end else begin
          want = expected_replies.pop_front();
          if (out_result_index !== want.index)
            flag($sformatf("result_index expected %0d got %0d", want.index, out_result_index));
          if (out_result_empty !== want.empty)
            flag($sformatf("result_empty expected %0d got %0d", want.empty, out_result_empty));
          if (out_status !== want.status)
            flag($sformatf("status expected %0d got %0d", want.status, out_status));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_replies.push_back(allocator_reply(cmd_t'(in_cmd), in_index, in_set_empty));
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
        entry_count = cfg_data;
    end
    replies_pending = expected_replies.size();
  end

endmodule

FILE: verif/free_list_allocator_test.sv
`timescale 1ns / 100ps

module free_list_allocator_test
  import fla_pkg::*;
();

  localparam int TABLE_DEPTH = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 120;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  cmd_t             in_cmd;
  logic [IDX_W-1:0] in_index;
  logic             in_set_empty;
  logic             out_valid;
  logic [IDX_W-1:0] out_result_index;
  logic             out_result_empty;
  logic [1:0]       out_status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  int               mismatch_count;
  int               replies_pending;
  int               quiet_cycles = 0;
  bit               no_gaps = 1'b0;
  int unsigned      phase_counts [12];

  free_list_allocator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_set_empty     (in_set_empty),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_result_empty (out_result_empty),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  free_list_allocator_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_set_empty     (in_set_empty),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_result_empty (out_result_empty),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .replies_pending  (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall watchdog: no request, result or register write for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // busy only moves at rising edges, so the falling edge shows what the next edge sees
  task automatic send(input cmd_t c, input logic [IDX_W-1:0] idx, input logic se);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= c;
    in_index     <= idx;
    in_set_empty <= se;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (replies_pending != 0 || busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic set_entry_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(input int n);
    cmd_t             c;
    logic [IDX_W-1:0] idx;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) c = CMD_ALLOC;
    else if (pick < 72) c = CMD_FREE;
    else if (pick < 94) c = CMD_SET_HEAD;
    else c = CMD_REBUILD;
    // mostly live indices, some past the chained range
    if (n == 0 || $urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, 255));
    else idx = IDX_W'($urandom_range(0, n - 1));
    send(c, idx, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int n;
    int p;
    int k;
    start        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    in_cmd       <= CMD_ALLOC;
    in_index     <= '0;
    in_set_empty <= 1'b0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // full table after reset
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_FREE, 8'd0, 1'b0);
    send(CMD_FREE, 8'd0, 1'b0);       // double free makes entry 0 link to itself
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_SET_HEAD, 8'd255, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_SET_HEAD, 8'd0, 1'b1);   // empty old head
    send(CMD_SET_HEAD, 8'd100, 1'b0);
    send(CMD_SET_HEAD, 8'd200, 1'b1);
    send(CMD_FREE, 8'd255, 1'b0);
    send(CMD_FREE, 8'd128, 1'b0);
    send(CMD_REBUILD, 8'd0, 1'b0);

    // zero entries: every index is out of range
    set_entry_count(9'd0);
    send(CMD_FREE, 8'd0, 1'b0);
    send(CMD_SET_HEAD, 8'd7, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_REBUILD, 8'd0, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);
    send(CMD_SET_HEAD, 8'd0, 1'b0);

    // count above the table saturates
    set_entry_count(9'd511);
    send(CMD_REBUILD, 8'd0, 1'b0);
    send(CMD_FREE, 8'd255, 1'b0);
    send(CMD_ALLOC, 8'd0, 1'b0);

    phase_counts = '{1, 2, 5, 16, 0, 255, 256, 300, 128, 511, 256, 0};
    phase_counts[11] = $urandom_range(3, 254);
    for (p = 0; p < 12; p++) begin
      set_entry_count(CNT_W'(phase_counts[p]));
      n = (phase_counts[p] > 256) ? 256 : phase_counts[p];
      if ($urandom_range(0, 3) != 0) send(CMD_REBUILD, 8'd0, 1'b0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 30 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 49) == 0) wait_idle();
        random_request(n);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && replies_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
